// File: sv/vec3_fixed_point_alu_unit_assert.svh
// Assertion macros used by the port-level checker of the vector ALU.
`ifndef VEC3_FIXED_POINT_ALU_UNIT_ASSERT_SVH
`define VEC3_FIXED_POINT_ALU_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define VFA_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vfa assertion failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define VFA_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vfa assertion failed");

`endif

// File: sv/vfa_pkg.sv
// Shared types, constants and fixed-point helpers of the vector ALU.
package vfa_pkg;

  localparam int VECTOR_DIMS = 3;
  localparam int FIX_W       = 32;
  localparam int FRAC_W      = 16;
  localparam int PROD_W      = 2 * FIX_W;
  localparam int ACC_W       = PROD_W + 2;
  localparam int QUEUE_DEPTH = 4;

  typedef logic signed [FIX_W-1:0] fix_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_SCALE = 3'd2,
    OP_DOT   = 3'd3,
    OP_CROSS = 3'd4,
    OP_LEN   = 3'd5,
    OP_NORM  = 3'd6,
    OP_NONE  = 3'd7
  } op_t;

  typedef struct packed {
    op_t                        op;
    fix_t [VECTOR_DIMS-1:0]     a;
    fix_t [VECTOR_DIMS-1:0]     b;
    fix_t                       scale;
  } item_t;

  typedef struct packed {
    fix_t val;
    logic ov;
  } sat_t;

  localparam fix_t FIX_MAX = 32'sh7FFFFFFF;
  localparam fix_t FIX_MIN = 32'sh80000000;
  localparam acc_t ACC_MAX = acc_t'(FIX_MAX);
  localparam acc_t ACC_MIN = acc_t'(FIX_MIN);
  localparam acc_t ACC_HALF = acc_t'(1 << (FRAC_W - 1));

  // Clamp a wide signed value into Q16.16.
  function automatic sat_t sat_acc(input acc_t v);
    sat_t r;
    r.ov  = 1'b0;
    r.val = fix_t'(v[FIX_W-1:0]);
    if (v > ACC_MAX) begin
      r.val = FIX_MAX;
      r.ov  = 1'b1;
    end else if (v < ACC_MIN) begin
      r.val = FIX_MIN;
      r.ov  = 1'b1;
    end
    return r;
  endfunction

  // Q32.32 to Q16.16, nearest, ties toward plus infinity.
  function automatic acc_t round_q(input acc_t v);
    return (v + ACC_HALF) >>> FRAC_W;
  endfunction

endpackage

// File: sv/vfa_front.sv
// Front end: input register that takes beats and classifies the operation.
module vfa_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         req_type,
  input  vfa_pkg::fix_t      a_x,
  input  vfa_pkg::fix_t      a_y,
  input  vfa_pkg::fix_t      a_z,
  input  vfa_pkg::fix_t      b_x,
  input  vfa_pkg::fix_t      b_y,
  input  vfa_pkg::fix_t      b_z,
  input  vfa_pkg::fix_t      scale_in,
  output logic               push_valid,
  input  logic               push_ready,
  output vfa_pkg::item_t     push_item
);

  logic           hold_v;
  vfa_pkg::item_t item;
  vfa_pkg::item_t item_next;

  assign in_ready   = !hold_v || push_ready;
  assign push_valid = hold_v;
  assign push_item  = item;

  always_comb begin
    item_next.op    = vfa_pkg::op_t'(req_type);
    item_next.a     = {a_z, a_y, a_x};
    item_next.b     = {b_z, b_y, b_x};
    item_next.scale = scale_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v <= 1'b0;
    end else if (in_ready) begin
      hold_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_next;
    end
  end

endmodule

// File: sv/vfa_queue.sv
// Short FIFO between the front end and the arithmetic back end.
module vfa_queue #(
  parameter int DEPTH = vfa_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  vfa_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output vfa_pkg::item_t pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  vfa_pkg::item_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

// File: sv/vfa_back.sv
// Back end: multiply, sum, round, bit-serial-per-stage sqrt and divide pipeline.
module vfa_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  vfa_pkg::item_t pop_item,
  output logic           out_valid,
  input  logic           out_ready,
  output vfa_pkg::fix_t  res_x,
  output vfa_pkg::fix_t  res_y,
  output vfa_pkg::fix_t  res_z,
  output vfa_pkg::fix_t  res_scalar,
  output logic           overflow,
  output logic           zero_length
);

  localparam int DIMS     = vfa_pkg::VECTOR_DIMS;
  localparam int FIX_W    = vfa_pkg::FIX_W;
  localparam int FRAC_W   = vfa_pkg::FRAC_W;
  localparam int PROD_W   = vfa_pkg::PROD_W;
  localparam int SQ_STEPS = PROD_W / 2;
  localparam int ROOT_W   = SQ_STEPS;
  localparam int REM_W    = ROOT_W + 4;
  localparam int LEN_W    = ROOT_W + 1;
  localparam int Q_W      = FRAC_W + 2;
  localparam int DV_STEPS = Q_W;
  localparam int NUM_W    = FIX_W + FRAC_W;
  localparam int DVD_W    = NUM_W + 2;
  localparam int DIV_W    = LEN_W + 1;
  localparam int DREM_W   = DIV_W + Q_W;
  localparam int NST      = 3 + SQ_STEPS + 1 + DV_STEPS + 1;

  typedef struct packed {
    vfa_pkg::op_t                op;
    vfa_pkg::fix_t [DIMS:0]      res;   // res[DIMS] is the scalar result
    logic                        ov;
    logic                        zl;
    vfa_pkg::fix_t [DIMS-1:0]    a;
  } ct_t;

  logic           en;
  logic [NST-1:0] vld;

  assign en        = !vld[NST-1] || out_ready;
  assign pop_ready = en;
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], pop_valid};
    end
  end

  // ---------------- stage 1: products or sums per lane ----------------
  ct_t                      s1_c;
  logic signed [PROD_W-1:0] s1_p [2*DIMS];

  for (genvar i = 0; i < DIMS; i++) begin : g_mul
    localparam int J = (i + 1) % DIMS;
    localparam int K = (i + 2) % DIMS;
    logic signed [FIX_W-1:0]  xa;
    logic signed [FIX_W-1:0]  ya;
    logic signed [FIX_W-1:0]  xb;
    logic signed [FIX_W-1:0]  yb;
    logic signed [PROD_W-1:0] pa;
    logic signed [PROD_W-1:0] pb;
    logic signed [PROD_W-1:0] ea;
    logic signed [PROD_W-1:0] eb;
    logic signed [PROD_W-1:0] sel;

    always_comb begin
      xa = pop_item.a[i];
      ya = pop_item.b[i];
      xb = pop_item.a[K];
      yb = pop_item.b[J];
      case (pop_item.op) inside
        vfa_pkg::OP_SCALE: ya = pop_item.scale;
        vfa_pkg::OP_CROSS: begin
          xa = pop_item.a[J];
          ya = pop_item.b[K];
        end
        vfa_pkg::OP_LEN, vfa_pkg::OP_NORM: ya = pop_item.a[i];
        default: ;
      endcase
    end

    assign pa = xa * ya;
    assign pb = xb * yb;
    assign ea = PROD_W'($signed(pop_item.a[i]));
    assign eb = PROD_W'($signed(pop_item.b[i]));

    always_comb begin
      case (pop_item.op) inside
        vfa_pkg::OP_ADD: sel = ea + eb;
        vfa_pkg::OP_SUB: sel = ea - eb;
        default:         sel = pa;
      endcase
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s1_p[i]        <= sel;
        s1_p[i + DIMS] <= pb;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_c.op  <= pop_item.op;
      s1_c.a   <= pop_item.a;
      s1_c.res <= '0;
      s1_c.ov  <= 1'b0;
      s1_c.zl  <= 1'b0;
    end
  end

  // ---------------- stage 2: exact wide sums ----------------
  ct_t           s2_c;
  vfa_pkg::acc_t s2_acc [DIMS];
  vfa_pkg::acc_t s2_n   [DIMS];
  vfa_pkg::acc_t dsum;

  always_comb begin
    dsum = '0;
    for (int i = 0; i < DIMS; i++) begin
      dsum = dsum + vfa_pkg::acc_t'(s1_p[i]);
    end
    for (int i = 0; i < DIMS; i++) begin
      case (s1_c.op) inside
        vfa_pkg::OP_CROSS:
          s2_n[i] = vfa_pkg::acc_t'(s1_p[i]) - vfa_pkg::acc_t'(s1_p[i + DIMS]);
        vfa_pkg::OP_DOT, vfa_pkg::OP_LEN, vfa_pkg::OP_NORM:
          s2_n[i] = (i == 0) ? dsum : '0;
        default:
          s2_n[i] = vfa_pkg::acc_t'(s1_p[i]);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_c   <= s1_c;
      s2_acc <= s2_n;
    end
  end

  // ---------------- stage 3: round and saturate ----------------
  ct_t               st3;
  ct_t               sq_c    [SQ_STEPS+1];
  logic [PROD_W-1:0] sq_s    [SQ_STEPS+1];
  logic [REM_W-1:0]  sq_rem  [SQ_STEPS+1];
  logic [ROOT_W-1:0] sq_root [SQ_STEPS+1];

  always_comb begin
    vfa_pkg::sat_t sr;
    sr      = '0;
    st3     = s2_c;
    st3.res = '0;
    st3.ov  = 1'b0;
    for (int i = 0; i < DIMS; i++) begin
      case (s2_c.op) inside
        vfa_pkg::OP_ADD, vfa_pkg::OP_SUB: begin
          sr         = vfa_pkg::sat_acc(s2_acc[i]);
          st3.res[i] = sr.val;
          st3.ov     = st3.ov | sr.ov;
        end
        vfa_pkg::OP_SCALE, vfa_pkg::OP_CROSS: begin
          sr         = vfa_pkg::sat_acc(vfa_pkg::round_q(s2_acc[i]));
          st3.res[i] = sr.val;
          st3.ov     = st3.ov | sr.ov;
        end
        default: ;
      endcase
    end
    if (s2_c.op == vfa_pkg::OP_DOT) begin
      sr            = vfa_pkg::sat_acc(vfa_pkg::round_q(s2_acc[0]));
      st3.res[DIMS] = sr.val;
      st3.ov        = sr.ov;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_c[0]    <= st3;
      sq_s[0]    <= s2_acc[0][PROD_W-1:0];
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
    end
  end

  // ---------------- square root, one root bit per stage ----------------
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    logic [REM_W-1:0] cur;
    logic [REM_W-1:0] trial;
    logic             ge;

    assign cur   = {sq_rem[k][REM_W-3:0], sq_s[k][PROD_W-1 -: 2]};
    assign trial = REM_W'({sq_root[k], 2'b01});
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        sq_c[k+1]    <= sq_c[k];
        sq_s[k+1]    <= sq_s[k] << 2;
        sq_rem[k+1]  <= ge ? (cur - trial) : cur;
        sq_root[k+1] <= {sq_root[k][ROOT_W-2:0], ge};
      end
    end
  end

  // ---------------- length rounding and divide setup ----------------
  logic [LEN_W-1:0]  len;
  ct_t               ln_c;
  logic [DREM_W-1:0] ln_rem [DIMS];
  ct_t               dv_c   [DV_STEPS+1];
  logic [DIV_W-1:0]  dv_d   [DV_STEPS+1];
  logic [DREM_W-1:0] dv_rem [DV_STEPS+1][DIMS];
  logic [Q_W-1:0]    dv_q   [DV_STEPS+1][DIMS];

  assign len = LEN_W'(sq_root[SQ_STEPS])
             + LEN_W'(sq_rem[SQ_STEPS] > REM_W'(sq_root[SQ_STEPS]));

  always_comb begin
    logic [FIX_W:0]   ext;
    logic [FIX_W:0]   mag;
    logic [DVD_W-1:0] dvd;
    ln_c = sq_c[SQ_STEPS];
    ext  = '0;
    mag  = '0;
    dvd  = '0;
    if (ln_c.op == vfa_pkg::OP_LEN) begin
      if (len[LEN_W-1:FIX_W-1] != '0) begin
        ln_c.res[DIMS] = vfa_pkg::FIX_MAX;
        ln_c.ov        = 1'b1;
      end else begin
        ln_c.res[DIMS] = vfa_pkg::fix_t'(len[FIX_W-1:0]);
      end
    end
    if (ln_c.op == vfa_pkg::OP_NORM) begin
      ln_c.zl = (len == '0);
    end
    for (int i = 0; i < DIMS; i++) begin
      ext       = {ln_c.a[i][FIX_W-1], ln_c.a[i]};
      mag       = ext[FIX_W] ? (~ext + 1'b1) : ext;
      dvd       = DVD_W'({mag[FIX_W-1:0], {FRAC_W{1'b0}}, 1'b0}) + DVD_W'(len);
      ln_rem[i] = DREM_W'(dvd);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_c[0]   <= ln_c;
      dv_d[0]   <= {len, 1'b0};
      dv_rem[0] <= ln_rem;
      for (int i = 0; i < DIMS; i++) begin
        dv_q[0][i] <= '0;
      end
    end
  end

  // ---------------- restoring divide, one quotient bit per stage ----------------
  for (genvar j = 0; j < DV_STEPS; j++) begin : g_div
    localparam int K = Q_W - 1 - j;
    logic [DREM_W-1:0] shd;

    assign shd = DREM_W'(dv_d[j]) << K;

    always_ff @(posedge clk) begin
      if (en) begin
        dv_c[j+1] <= dv_c[j];
        dv_d[j+1] <= dv_d[j];
      end
    end

    for (genvar i = 0; i < DIMS; i++) begin : g_lane
      logic ge;
      assign ge = (dv_rem[j][i] >= shd);

      always_ff @(posedge clk) begin
        if (en) begin
          dv_rem[j+1][i] <= ge ? (dv_rem[j][i] - shd) : dv_rem[j][i];
          dv_q[j+1][i]   <= dv_q[j][i] | (Q_W'(ge) << K);
        end
      end
    end
  end

  // ---------------- output register ----------------
  ct_t oc;
  ct_t out_c;

  always_comb begin
    vfa_pkg::fix_t qq;
    qq = '0;
    oc = dv_c[DV_STEPS];
    if (oc.op == vfa_pkg::OP_NORM) begin
      oc.res = '0;
      if (!oc.zl) begin
        for (int i = 0; i < DIMS; i++) begin
          qq        = vfa_pkg::fix_t'(dv_q[DV_STEPS][i]);
          oc.res[i] = oc.a[i][FIX_W-1] ? -qq : qq;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_c <= oc;
    end
  end

  assign res_x       = out_c.res[0];
  assign res_y       = out_c.res[1];
  assign res_z       = out_c.res[2];
  assign res_scalar  = out_c.res[DIMS];
  assign overflow    = out_c.ov;
  assign zero_length = out_c.zl;

endmodule

// File: sv/vec3_fixed_point_alu_unit.sv
// Top level of the three-component Q16.16 vector ALU.
//
// Input channel (in_valid/in_ready): one beat carries req_type, vectors a and
// b and scale_in. Output channel (out_valid/out_ready): one beat per input
// beat, in order, with res_x/y/z, res_scalar, overflow and zero_length.
// Throughput: one beat per cycle sustained while out_ready is high; the back
// end is a 55-stage pipeline whose depth is set by the square root (one root
// bit per stage, 32 stages) and the normalize divider (one quotient bit per
// stage, 18 stages). A beat passes the front register, the queue and the
// back pipeline before out_valid rises.
// A 4-entry queue sits between front and back; when a result waits with
// out_ready low the whole back pipeline holds, the queue fills, then in_ready
// drops.
// Reset (rst, synchronous) empties the front register, the queue and all
// pipeline valid bits; no beat is presented until new input arrives.
module vec3_fixed_point_alu_unit #(
  parameter int QUEUE_DEPTH = vfa_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [2:0]    req_type,
  input  vfa_pkg::fix_t a_x,
  input  vfa_pkg::fix_t a_y,
  input  vfa_pkg::fix_t a_z,
  input  vfa_pkg::fix_t b_x,
  input  vfa_pkg::fix_t b_y,
  input  vfa_pkg::fix_t b_z,
  input  vfa_pkg::fix_t scale_in,
  output logic          out_valid,
  input  logic          out_ready,
  output vfa_pkg::fix_t res_x,
  output vfa_pkg::fix_t res_y,
  output vfa_pkg::fix_t res_z,
  output vfa_pkg::fix_t res_scalar,
  output logic          overflow,
  output logic          zero_length
);

  // front -> queue
  logic           fq_valid;
  logic           fq_ready;
  vfa_pkg::item_t fq_item;
  // queue -> back
  logic           qb_valid;
  logic           qb_ready;
  vfa_pkg::item_t qb_item;

  // Front: registers the beat and decodes the operation code.
  vfa_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .a_x        (a_x),
    .a_y        (a_y),
    .a_z        (a_z),
    .b_x        (b_x),
    .b_y        (b_y),
    .b_z        (b_z),
    .scale_in   (scale_in),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_item  (fq_item)
  );

  // Decoupling queue: lets the front keep taking beats during short stalls.
  vfa_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_item  (fq_item),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_item   (qb_item)
  );

  // Back: arithmetic pipeline, ends in the output register.
  vfa_back u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (qb_valid),
    .pop_ready   (qb_ready),
    .pop_item    (qb_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .res_x       (res_x),
    .res_y       (res_y),
    .res_z       (res_z),
    .res_scalar  (res_scalar),
    .overflow    (overflow),
    .zero_length (zero_length)
  );

endmodule

// File: sv/vfa_checker.sv
// Port-level checker for the vector ALU output channel, with its bind.
`include "vec3_fixed_point_alu_unit_assert.svh"

module vfa_checker (
  input logic          clk,
  input logic          rst,
  input logic          out_valid,
  input logic          out_ready,
  input vfa_pkg::fix_t res_x,
  input vfa_pkg::fix_t res_y,
  input vfa_pkg::fix_t res_z,
  input vfa_pkg::fix_t res_scalar,
  input logic          overflow,
  input logic          zero_length
);

  // x, y, z, scalar packed high to low
  logic [127:0] res_all;

  assign res_all = {res_x, res_y, res_z, res_scalar};

  // stalled beat holds
  `VFA_ASSERT_NXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(res_all))

  // zero-length normalize gives all zeros and no overflow
  `VFA_ASSERT_IMP(a_zero_len, out_valid && zero_length, !overflow && res_all == '0)

  // scalar results leave the vector fields clear
  `VFA_ASSERT_IMP(a_scalar_only, out_valid && res_scalar != 0, res_all[127:32] == '0)

  // a saturated result is never zero
  `VFA_ASSERT_IMP(a_ovf_nonzero, out_valid && overflow, res_all != '0)

endmodule

bind vec3_fixed_point_alu_unit vfa_checker u_vfa_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .res_x       (res_x),
  .res_y       (res_y),
  .res_z       (res_z),
  .res_scalar  (res_scalar),
  .overflow    (overflow),
  .zero_length (zero_length)
);

// File: verif/vec3_alu_checker.sv
// Checker for the vector ALU: predicts each result from the input beats and compares.
`timescale 1ns / 100ps
module vec3_alu_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_ready,
  input  logic [2:0]    req_type,
  input  vfa_pkg::fix_t a_x,
  input  vfa_pkg::fix_t a_y,
  input  vfa_pkg::fix_t a_z,
  input  vfa_pkg::fix_t b_x,
  input  vfa_pkg::fix_t b_y,
  input  vfa_pkg::fix_t b_z,
  input  vfa_pkg::fix_t scale_in,
  input  logic          out_valid,
  input  logic          out_ready,
  input  vfa_pkg::fix_t res_x,
  input  vfa_pkg::fix_t res_y,
  input  vfa_pkg::fix_t res_z,
  input  vfa_pkg::fix_t res_scalar,
  input  logic          overflow,
  input  logic          zero_length,
  output int            errors,
  output int            pending
);

  typedef struct packed {
    vfa_pkg::fix_t x, y, z, s;
    logic ov, zl;
  } alu_res_t;

  alu_res_t expected_q[$];

  function automatic vfa_pkg::fix_t clamp32(input longint v, inout logic ov);
    if (v > 64'sd2147483647) begin
      ov = 1'b1;
      return vfa_pkg::FIX_MAX;
    end
    if (v < -64'sd2147483648) begin
      ov = 1'b1;
      return vfa_pkg::FIX_MIN;
    end
    return vfa_pkg::fix_t'(v);
  endfunction

  // Sum of Q32.32 products rounded half up; 66-bit to hold three full products.
  function automatic longint prod_round(logic signed [65:0] sum);
    logic signed [65:0] r;
    r = (sum + 66'sd32768) >>> 16;
    if (r > 66'sd4294967296) return 64'sd4294967296;
    if (r < -66'sd4294967296) return -64'sd4294967296;
    return longint'(r);
  endfunction

  function automatic logic [63:0] root_nearest(logic [63:0] s);
    logic [63:0] r, bt;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > s) bt >>= 2;
    while (bt != 0) begin
      if (s >= r + bt) begin
        s -= r + bt;
        r = (r >> 1) + bt;
      end else begin
        r >>= 1;
      end
      bt >>= 2;
    end
    if (s > r) r++;
    return r;
  endfunction

  function automatic alu_res_t predict_vec3(logic [2:0] op,
                                            vfa_pkg::fix_t ax, vfa_pkg::fix_t ay,
                                            vfa_pkg::fix_t az, vfa_pkg::fix_t bx,
                                            vfa_pkg::fix_t by, vfa_pkg::fix_t bz,
                                            vfa_pkg::fix_t sc);
    alu_res_t o;
    longint a[3], b[3], num, q, l;
    logic signed [65:0] sum;
    logic [63:0] sq;
    int j, k;
    o = '0;
    a[0] = ax; a[1] = ay; a[2] = az;
    b[0] = bx; b[1] = by; b[2] = bz;
    case (vfa_pkg::op_t'(op)) inside
      vfa_pkg::OP_ADD: begin
        o.x = clamp32(a[0] + b[0], o.ov);
        o.y = clamp32(a[1] + b[1], o.ov);
        o.z = clamp32(a[2] + b[2], o.ov);
      end
      vfa_pkg::OP_SUB: begin
        o.x = clamp32(a[0] - b[0], o.ov);
        o.y = clamp32(a[1] - b[1], o.ov);
        o.z = clamp32(a[2] - b[2], o.ov);
      end
      vfa_pkg::OP_SCALE: begin
        o.x = clamp32(prod_round(66'(a[0] * longint'(sc))), o.ov);
        o.y = clamp32(prod_round(66'(a[1] * longint'(sc))), o.ov);
        o.z = clamp32(prod_round(66'(a[2] * longint'(sc))), o.ov);
      end
      vfa_pkg::OP_DOT: begin
        sum = 66'(a[0] * b[0]) + 66'(a[1] * b[1]) + 66'(a[2] * b[2]);
        o.s = clamp32(prod_round(sum), o.ov);
      end
      vfa_pkg::OP_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          j = (i + 1) % 3;
          k = (i + 2) % 3;
          sum = 66'(a[j] * b[k]) - 66'(a[k] * b[j]);
          q = prod_round(sum);
          if (i == 0) o.x = clamp32(q, o.ov);
          else if (i == 1) o.y = clamp32(q, o.ov);
          else o.z = clamp32(q, o.ov);
        end
      end
      vfa_pkg::OP_LEN, vfa_pkg::OP_NORM: begin
        sq = 64'(a[0] * a[0]) + 64'(a[1] * a[1]) + 64'(a[2] * a[2]);
        sq = root_nearest(sq);
        if (vfa_pkg::op_t'(op) == vfa_pkg::OP_LEN) begin
          o.s = clamp32(longint'(sq), o.ov);
        end else if (sq == 0) begin
          o.zl = 1'b1;
        end else begin
          l = longint'(sq);
          for (int i = 0; i < 3; i++) begin
            num = a[i] * 65536;
            if (num >= 0) q = (2 * num + l) / (2 * l);
            else q = -((2 * (-num) + l) / (2 * l));
            if (i == 0) o.x = clamp32(q, o.ov);
            else if (i == 1) o.y = clamp32(q, o.ov);
            else o.z = clamp32(q, o.ov);
          end
        end
      end
      default: o = '0;
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  assign pending = expected_q.size();

  always @(posedge clk) begin
    alu_res_t e;
    if (!rst) begin
      if (in_valid && in_ready)
        expected_q.insert(expected_q.size(),
                          predict_vec3(req_type, a_x, a_y, a_z, b_x, b_y, b_z, scale_in));
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected beat", 0, 0);
        end else begin
          e = expected_q.pop_front();
          if (res_x !== e.x) report_mismatch("res_x", res_x, e.x);
          if (res_y !== e.y) report_mismatch("res_y", res_y, e.y);
          if (res_z !== e.z) report_mismatch("res_z", res_z, e.z);
          if (res_scalar !== e.s) report_mismatch("res_scalar", res_scalar, e.s);
          if (overflow !== e.ov)
            report_mismatch("overflow", 32'(overflow), 32'(e.ov));
          if (zero_length !== e.zl)
            report_mismatch("zero_length", 32'(zero_length), 32'(e.zl));
        end
      end
    end
  end
endmodule

// File: verif/tb_vec3_fixed_point_alu_unit.sv
// Testbench top for the vector ALU: stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps
module tb_vec3_fixed_point_alu_unit;

  localparam int RANDOM_BEATS = 2000;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 80;
  localparam vfa_pkg::fix_t MAXV = vfa_pkg::FIX_MAX;
  localparam vfa_pkg::fix_t MINV = vfa_pkg::FIX_MIN;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] req_type = '0;
  vfa_pkg::fix_t a_x = '0, a_y = '0, a_z = '0, b_x = '0, b_y = '0, b_z = '0;
  vfa_pkg::fix_t scale_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  vfa_pkg::fix_t res_x, res_y, res_z, res_scalar;
  logic overflow, zero_length;
  int errors, pending;
  int cycles = 0;
  // long receiver hold-off: stimulus toggles the request, receiver acknowledges
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;

  always #10 clk = ~clk;

  vec3_fixed_point_alu_unit uut (.*);

  vec3_alu_checker chk (.*);

  // Timeout watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_vec3_fixed_point_alu_unit: done, errors");
      $finish;
    end
  end

  // Receiver: random stall pattern, plus a long hold-off on request.
  initial begin
    int mode, run;
    @(posedge clk iff !rst);
    forever begin
      if (hold_req != hold_done) begin
        out_ready <= 1'b0;
        repeat (150) @(posedge clk);
        hold_done <= hold_req;
      end
      mode = $urandom_range(0, 3);
      run = $urandom_range(1, 40);
      repeat (run) begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          2: out_ready <= ($urandom_range(0, 1) != 0);
          default: out_ready <= ($urandom_range(0, 4) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Corner values that exercise saturation and rounding edges.
  function automatic vfa_pkg::fix_t pick_value();
    case ($urandom_range(0, 9))
      0: return MAXV;
      1: return MINV;
      2: return vfa_pkg::fix_t'(0);
      3: return vfa_pkg::fix_t'($urandom_range(0, 131072)) - vfa_pkg::fix_t'(65536);
      4: return vfa_pkg::fix_t'($urandom) >>> $urandom_range(8, 30);
      5: return vfa_pkg::fix_t'(32'h8000 + $urandom_range(0, 1) * 32'h10000);
      default: return vfa_pkg::fix_t'($urandom);
    endcase
  endfunction

  // Present one beat and hold it until taken.
  task automatic send_beat(logic [2:0] op, vfa_pkg::fix_t ax, vfa_pkg::fix_t ay,
                           vfa_pkg::fix_t az, vfa_pkg::fix_t bx, vfa_pkg::fix_t by,
                           vfa_pkg::fix_t bz, vfa_pkg::fix_t sc);
    in_valid <= 1'b1;
    req_type <= op;
    a_x <= ax; a_y <= ay; a_z <= az;
    b_x <= bx; b_y <= by; b_z <= bz;
    scale_in <= sc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_random();
    send_beat(3'($urandom_range(0, 7)), pick_value(), pick_value(), pick_value(),
              pick_value(), pick_value(), pick_value(), pick_value());
  endtask

  initial begin
    int burst, gap;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed beats: every op, extremes, zero-length normalize, OP_NONE.
    send_beat(vfa_pkg::OP_ADD, MAXV, MINV, 1, 1, -1, 5, 0);
    send_beat(vfa_pkg::OP_SUB, MINV, MAXV, 0, 1, -1, 0, 0);
    send_beat(vfa_pkg::OP_SCALE, 32'h10000, -32'h10000, MAXV, 0, 0, 0, 32'h18000);
    send_beat(vfa_pkg::OP_SCALE, 1, -1, MINV, 0, 0, 0, 32'h8000);
    send_beat(vfa_pkg::OP_SCALE, MINV, MAXV, 3, 0, 0, 0, MINV);
    send_beat(vfa_pkg::OP_DOT, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, 0);
    send_beat(vfa_pkg::OP_DOT, MINV, MINV, MINV, MINV, MINV, MINV, 0);
    send_beat(vfa_pkg::OP_DOT, 32'h10000, 32'h20000, 0, 32'h30000, -32'h10000, 7, 0);
    send_beat(vfa_pkg::OP_CROSS, 32'h10000, 0, 0, 0, 32'h10000, 0, 0);
    send_beat(vfa_pkg::OP_CROSS, MAXV, MINV, MAXV, MINV, MAXV, MINV, 0);
    send_beat(vfa_pkg::OP_LEN, 32'h30000, 32'h40000, 0, 0, 0, 0, 0);
    send_beat(vfa_pkg::OP_LEN, 0, 0, 0, 0, 0, 0, 0);
    send_beat(vfa_pkg::OP_LEN, MINV, MINV, MINV, 0, 0, 0, 0);
    send_beat(vfa_pkg::OP_NORM, 0, 0, 0, 1, 2, 3, 4);
    send_beat(vfa_pkg::OP_NORM, 1, 0, 0, 0, 0, 0, 0);
    send_beat(vfa_pkg::OP_NORM, MINV, MAXV, -1, 0, 0, 0, 0);
    send_beat(vfa_pkg::OP_NORM, 32'h30000, -32'h40000, 0, 0, 0, 0, 0);
    send_beat(vfa_pkg::OP_NONE, MAXV, MINV, 1, 2, 3, 4, 5);

    // Fill the pipeline while the receiver holds off.
    hold_req <= ~hold_req;
    in_valid <= 1'b0;
    @(posedge clk);
    repeat (120) send_random();
    // Pause until everything has drained.
    in_valid <= 1'b0;
    @(posedge clk iff (pending == 0));

    for (int n = 0; n < RANDOM_BEATS; n += burst) begin
      burst = $urandom_range(1, 30);
      repeat (burst) send_random();
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    @(posedge clk iff (pending == 0));
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("tb_vec3_fixed_point_alu_unit: done, clean");
    else
      $display("tb_vec3_fixed_point_alu_unit: done, errors");
    $finish;
  end
endmodule
